// File: design/mtlp_pkg.sv
`timescale 1ns / 1ps
package mtlp_pkg;

    localparam int LINE_BYTES_DEF = 1024;
    localparam int MAX_TOKENS_DEF = 16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] KEY_NONE = 3'd7;
    localparam int BANNER_LEN = 17;

    localparam logic [2:0] PH_SKIP = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    localparam logic [0:0] CFG_ENABLE  = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] voltage_milli;
        logic signed [31:0] current_milli;
        logic signed [31:0] speed_milli;
        logic signed [31:0] ctrl_temp_milli;
        logic signed [31:0] motor_temp_milli;
        logic               booted;
        logic               alive;
        logic               line_end;
        logic               decode_ok;
    } out_item_t;

    function automatic logic [7:0] banner_char(input logic [4:0] pos);
        case (pos)
            5'd0:  banner_char = "M";
            5'd1:  banner_char = "o";
            5'd2:  banner_char = "t";
            5'd3:  banner_char = "o";
            5'd4:  banner_char = "r";
            5'd5:  banner_char = "l";
            5'd6:  banner_char = "o";
            5'd7:  banner_char = "o";
            5'd8:  banner_char = "p";
            5'd9:  banner_char = " ";
            5'd10: banner_char = "s";
            5'd11: banner_char = "t";
            5'd12: banner_char = "a";
            5'd13: banner_char = "r";
            5'd14: banner_char = "t";
            5'd15: banner_char = "e";
            5'd16: banner_char = "d";
            default: banner_char = 8'd0;
        endcase
    endfunction

    // key text: U, I, RPM, con, mot; zero past the key's length
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'd0;
        case (k)
            3'd0: if (pos == 3'd0) r = "U";
            3'd1: if (pos == 3'd0) r = "I";
            3'd2: case (pos) 3'd0: r = "R"; 3'd1: r = "P"; 3'd2: r = "M"; default: r = 8'd0; endcase
            3'd3: case (pos) 3'd0: r = "c"; 3'd1: r = "o"; 3'd2: r = "n"; default: r = 8'd0; endcase
            3'd4: case (pos) 3'd0: r = "m"; 3'd1: r = "o"; 3'd2: r = "t"; default: r = 8'd0; endcase
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] key_len(input logic [2:0] k);
        return (k < 3'd2) ? 3'd1 : 3'd3;
    endfunction

endpackage

// File: design/motor_telemetry_line_parser.sv
`timescale 1ns / 1ps
// An accepted item's result item is written to the output register on the edge that accepts it.
// One item is taken per cycle while the output register is free or being taken; the whole
// byte-wise line, token and number update sits between the state registers and the output register.
// Reset (aresetn low, synchronous): line state cleared, published values zero,
// monitor disabled, timeout 1000, countdown zero, no result held.
module motor_telemetry_line_parser #(
    parameter int LINE_BYTES = mtlp_pkg::LINE_BYTES_DEF,
    parameter int MAX_TOKENS = mtlp_pkg::MAX_TOKENS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtlp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mtlp_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam logic [2:0] KEY_NONE_L = mtlp_pkg::KEY_NONE;

    // line and token state
    logic [LW-1:0] line_length_reg, line_length_next;
    logic [TW-1:0] token_count_reg, token_count_next;
    logic          in_token_reg, in_token_next;
    logic [4:0]    key_match_reg, key_match_next;
    logic [2:0]    key_pos_reg, key_pos_next;
    logic [2:0]    pending_key_reg, pending_key_next;
    logic [31:0]   accum_reg, accum_next;
    logic [2:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [1:0]    frac_reg, frac_next;
    logic [31:0]   pend_reg [5];
    logic [31:0]   pend_next [5];
    logic [4:0]    found_reg, found_next;
    logic [4:0]    banner_pos_reg, banner_pos_next;
    logic          banner_seen_reg, banner_seen_next;
    logic          nul_seen_reg, nul_seen_next;
    logic          booted_reg, booted_next;
    logic [31:0]   pub_reg [5];
    logic [31:0]   pub_next [5];
    logic [15:0]   countdown_reg, countdown_next;
    logic          enable_reg;
    logic [15:0]   timeout_reg;
    logic          m_valid_reg;
    mtlp_pkg::out_item_t out_reg, out_next;

    logic accept;
    logic cfg_fire;

    // output register frees as it is taken, so a new item enters every cycle unless it is held full with m_ready low
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // number helpers
    function automatic logic [31:0] sat(input logic [36:0] t);
        return (t > 37'h80000000) ? 32'h80000000 : t[31:0];
    endfunction

    function automatic logic [31:0] num_value(input logic neg, input logic [31:0] a);
        if (neg) return 32'd0 - a;
        return (a > 32'h7fffffff) ? 32'h7fffffff : a;
    endfunction

    always_comb begin
        logic [7:0]  c;
        logic        le;
        logic        dok;
        logic        tok_end;
        logic [3:0]  d;
        logic [36:0] t;
        logic [9:0]  fs;
        logic        is_key_tok;
        logic [2:0]  ph;
        logic [2:0]  pk;
        logic [31:0] nv;

        line_length_next = line_length_reg;
        token_count_next = token_count_reg;
        in_token_next    = in_token_reg;
        key_match_next   = key_match_reg;
        key_pos_next     = key_pos_reg;
        pending_key_next = pending_key_reg;
        accum_next       = accum_reg;
        phase_next       = phase_reg;
        neg_next         = neg_reg;
        frac_next        = frac_reg;
        found_next       = found_reg;
        banner_pos_next  = banner_pos_reg;
        banner_seen_next = banner_seen_reg;
        nul_seen_next    = nul_seen_reg;
        booted_next      = booted_reg;
        countdown_next   = countdown_reg;
        for (int k = 0; k < 5; k++) begin
            pend_next[k] = pend_reg[k];
            pub_next[k]  = pub_reg[k];
        end
        c = s_data.rx_byte;
        le = 1'b0;
        dok = 1'b0;
        tok_end = 1'b0;
        d = c[3:0];
        t = '0;
        fs = '0;
        ph = phase_reg;
        pk = KEY_NONE_L;
        nv = '0;
        // parity of the current token: odd count means a key token
        is_key_tok = token_count_reg[0];

        if (s_data.operation == mtlp_pkg::OP_TICK) begin
            if (countdown_reg != 16'd0) countdown_next = countdown_reg - 16'd1;
        end else if (c == 8'd10) begin
            le = 1'b1;
            tok_end = in_token_reg;
        end else if (c != 8'd13) begin
            if (line_length_reg < LW'(LINE_BYTES)) begin
                line_length_next = line_length_reg + LW'(1);
                if (!nul_seen_reg) begin
                    if (c == 8'd0) begin
                        tok_end = in_token_reg;
                        nul_seen_next = 1'b1;
                    end else begin
                        // banner search with restart on 'M'
                        if (banner_pos_reg < 5'(mtlp_pkg::BANNER_LEN)) begin
                            if (c == mtlp_pkg::banner_char(banner_pos_reg))
                                banner_pos_next = banner_pos_reg + 5'd1;
                            else
                                banner_pos_next = (c == "M") ? 5'd1 : 5'd0;
                            if (banner_pos_next == 5'(mtlp_pkg::BANNER_LEN))
                                banner_seen_next = 1'b1;
                        end
                        if (c == "," || c == "=") begin
                            tok_end = in_token_reg;
                        end else begin
                            if (!in_token_reg && token_count_reg < TW'(MAX_TOKENS)) begin
                                // token start: even count before increment opens a key
                                if (!token_count_reg[0]) begin
                                    key_match_next   = 5'h1f;
                                    key_pos_next     = 3'd0;
                                    pending_key_next = KEY_NONE_L;
                                end else begin
                                    accum_next = '0;
                                    phase_next = mtlp_pkg::PH_SKIP;
                                    neg_next   = 1'b0;
                                    frac_next  = 2'd0;
                                end
                                token_count_next = token_count_reg + TW'(1);
                                in_token_next    = 1'b1;
                                is_key_tok       = !token_count_reg[0];
                            end
                            if (in_token_next) begin
                                if (is_key_tok) begin
                                    for (int k = 0; k < 5; k++) begin
                                        if (key_match_next[k] &&
                                            (key_pos_next >= mtlp_pkg::key_len(3'(k)) ||
                                             mtlp_pkg::key_char(3'(k), key_pos_next) != c))
                                            key_match_next[k] = 1'b0;
                                    end
                                    if (key_pos_next < 3'd7) key_pos_next = key_pos_next + 3'd1;
                                end else if (pending_key_next < 3'd5) begin
                                    ph = phase_next;
                                    if (ph == mtlp_pkg::PH_STOP) begin
                                    end else if (ph == mtlp_pkg::PH_SKIP && (c == " " ||
                                                 c == 8'h09 || c == 8'h0b || c == 8'h0c)) begin
                                    end else if (ph == mtlp_pkg::PH_SKIP &&
                                                 (c == "+" || c == "-")) begin
                                        if (c == "-") neg_next = 1'b1;
                                        phase_next = mtlp_pkg::PH_SIGN;
                                    end else if (c >= "0" && c <= "9") begin
                                        if (ph <= mtlp_pkg::PH_INT) begin
                                            t = 37'({accum_next, 3'b000}) +
                                                37'({accum_next, 1'b0}) +
                                                37'(d) * 37'd1000;
                                            accum_next = sat(t);
                                            phase_next = mtlp_pkg::PH_INT;
                                        end else if (frac_next < 2'd3) begin
                                            case (frac_next)
                                                2'd0:    fs = 10'd100;
                                                2'd1:    fs = 10'd10;
                                                default: fs = 10'd1;
                                            endcase
                                            t = 37'(accum_next) + 37'(d) * 37'(fs);
                                            accum_next = sat(t);
                                            frac_next  = frac_next + 2'd1;
                                        end
                                    end else if (c == "." && ph <= mtlp_pkg::PH_INT) begin
                                        phase_next = mtlp_pkg::PH_FRAC;
                                    end else begin
                                        phase_next = mtlp_pkg::PH_STOP;
                                    end
                                end
                            end
                        end
                    end
                end
            end else begin
                // overflow: drop the byte and restart the line
                le = 1'b0;
            end
        end

        // token end; only the current token's parity matters
        if (tok_end) begin
            if (token_count_reg[0]) begin
                pk = KEY_NONE_L;
                for (int k = 0; k < 5; k++)
                    if (key_match_next[k] && key_pos_next == mtlp_pkg::key_len(3'(k)) &&
                        !found_next[k])
                        pk = 3'(k);
                pending_key_next = pk;
            end else if (pending_key_next < 3'd5) begin
                nv = num_value(neg_next, accum_next);
                pend_next[pending_key_next] = nv;
                found_next[pending_key_next] = 1'b1;
                pending_key_next = KEY_NONE_L;
            end
            in_token_next = 1'b0;
        end

        if (le) begin
            if (banner_seen_next) begin
                booted_next = 1'b1;
            end else if (enable_reg) begin
                for (int k = 0; k < 5; k++)
                    if (found_next[k]) pub_next[k] = pend_next[k];
                dok = (found_next == 5'h1f);
                if (dok) countdown_next = timeout_reg;
            end
        end

        // line restart at line end or on overflow
        if (s_data.operation == mtlp_pkg::OP_BYTE && (le ||
            (c != 8'd13 && line_length_reg >= LW'(LINE_BYTES)))) begin
            line_length_next = '0;
            token_count_next = '0;
            in_token_next    = 1'b0;
            key_match_next   = 5'h1f;
            key_pos_next     = 3'd0;
            pending_key_next = KEY_NONE_L;
            accum_next       = '0;
            phase_next       = mtlp_pkg::PH_SKIP;
            neg_next         = 1'b0;
            frac_next        = 2'd0;
            found_next       = '0;
            for (int k = 0; k < 5; k++) pend_next[k] = '0;
            banner_pos_next  = '0;
            banner_seen_next = 1'b0;
            nul_seen_next    = 1'b0;
        end

        out_next.voltage_milli    = pub_next[0];
        out_next.current_milli    = pub_next[1];
        out_next.speed_milli      = pub_next[2];
        out_next.ctrl_temp_milli  = pub_next[3];
        out_next.motor_temp_milli = pub_next[4];
        out_next.booted           = booted_next;
        out_next.alive            = enable_reg && (countdown_next != 16'd0);
        out_next.line_end         = le;
        out_next.decode_ok        = dok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= '0;
            token_count_reg <= '0;
            in_token_reg    <= 1'b0;
            key_match_reg   <= 5'h1f;
            key_pos_reg     <= 3'd0;
            pending_key_reg <= KEY_NONE_L;
            accum_reg       <= '0;
            phase_reg       <= mtlp_pkg::PH_SKIP;
            neg_reg         <= 1'b0;
            frac_reg        <= 2'd0;
            found_reg       <= '0;
            banner_pos_reg  <= '0;
            banner_seen_reg <= 1'b0;
            nul_seen_reg    <= 1'b0;
            booted_reg      <= 1'b0;
            countdown_reg   <= '0;
            enable_reg      <= 1'b0;
            timeout_reg     <= 16'd1000;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                pend_reg[k] <= '0;
                pub_reg[k]  <= '0;
            end
        end else begin
            if (accept) begin
                line_length_reg <= line_length_next;
                token_count_reg <= token_count_next;
                in_token_reg    <= in_token_next;
                key_match_reg   <= key_match_next;
                key_pos_reg     <= key_pos_next;
                pending_key_reg <= pending_key_next;
                accum_reg       <= accum_next;
                phase_reg       <= phase_next;
                neg_reg         <= neg_next;
                frac_reg        <= frac_next;
                found_reg       <= found_next;
                banner_pos_reg  <= banner_pos_next;
                banner_seen_reg <= banner_seen_next;
                nul_seen_reg    <= nul_seen_next;
                booted_reg      <= booted_next;
                countdown_reg   <= countdown_next;
                for (int k = 0; k < 5; k++) begin
                    pend_reg[k] <= pend_next[k];
                    pub_reg[k]  <= pub_next[k];
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // the user must send configuration only while idle; the block itself does not enforce this
            if (cfg_fire) begin
                unique case (cfg_index)
                    mtlp_pkg::CFG_ENABLE: begin
                        enable_reg <= cfg_data[0];
                        if (cfg_data[0]) countdown_reg <= timeout_reg;
                    end
                    mtlp_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // hold the result item until taken
    always_ff @(posedge aclk) begin
        if (accept) out_reg <= out_next;
    end

endmodule
